[hdl/id3_pkg.sv]
package id3_pkg;

   // response queue depth, at least two (one item can push two results)
   localparam int RSP_DEPTH = 4;

   localparam logic [31:0] MAX_FRAME_SIZE_RST = 32'd524288;
   localparam logic [7:0]  MAX_TEXT_BYTES_RST = 8'd255;

   localparam int                  CSR_INDEX_W        = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_SIZE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TEXT_BYTES = 8'd1;

   // byte counter only has to be compared against a 28-bit tag size
   localparam int              POS_W   = 29;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [23:0] TAG_MAGIC = 24'h494433;   // "ID3"

   // TIT2, TPE1, TALB, APIC
   localparam logic [31:0] FRAME_IDS [4] = '{32'h54495432, 32'h54504531,
                                            32'h54414C42, 32'h41504943};

   localparam logic [2:0] KIND_TITLE   = 3'd0;
   localparam logic [2:0] KIND_ARTIST  = 3'd1;
   localparam logic [2:0] KIND_ALBUM   = 3'd2;
   localparam logic [2:0] KIND_PICTURE = 3'd3;
   localparam logic [2:0] KIND_FINISH  = 3'd4;

   localparam logic [7:0] ST_NO_TAG     = 8'd0;
   localparam logic [7:0] ST_TAG_END    = 8'd1;
   localparam logic [7:0] ST_PADDING    = 8'd2;
   localparam logic [7:0] ST_BAD_SIZE   = 8'd3;
   localparam logic [7:0] ST_FILE_ENDED = 8'd4;

   typedef enum logic [1:0] {
      PH_TAG_HDR,
      PH_FRAME_HDR,
      PH_PAYLOAD,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_TITLE,
      CLS_ARTIST,
      CLS_ALBUM,
      CLS_PICTURE
   } class_type;

   // text frames use STG_ENC, STG_MIME (text body) and STG_TYPE (closed)
   typedef enum logic [2:0] {
      STG_ENC,
      STG_MIME,
      STG_TYPE,
      STG_DESC,
      STG_IMAGE
   } stage_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       data_valid;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

[hdl/id3_parse_core.sv]
module id3_parse_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_file_end,
   input  logic [31:0]        max_frame_size,
   input  logic [7:0]         max_text_bytes,
   input  logic               rsp_room,
   output id3_pkg::push_type  push
);

   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  byte_ff;
   logic                        fe_ff;
   id3_pkg::phase_type          phase_ff, phase_in;
   logic [id3_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [27:0]                 tag_ff, tag_in;
   logic [63:0]                 shift_ff, shift_in;
   logic [3:0]                  hidx_ff, hidx_in;
   logic [31:0]                 left_ff, left_in;
   id3_pkg::class_type          cls_ff, cls_in;
   id3_pkg::stage_type          stage_ff, stage_in;
   logic [7:0]                  tcount_ff, tcount_in;
   logic [3:0]                  found_ff, found_in;
   logic                        run_open_ff, run_open_in;

   logic process;
   logic accept;

   assign process   = in_valid_ff && rsp_room;
   assign req_stall = in_valid_ff && !rsp_room;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (process ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_data_byte;
         fe_ff   <= req_file_end;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= id3_pkg::PH_TAG_HDR;
         pos_ff      <= '0;
         tag_ff      <= '0;
         shift_ff    <= '0;
         hidx_ff     <= '0;
         left_ff     <= '0;
         cls_ff      <= id3_pkg::CLS_NONE;
         stage_ff    <= id3_pkg::STG_ENC;
         tcount_ff   <= '0;
         found_ff    <= '0;
         run_open_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         tag_ff      <= tag_in;
         shift_ff    <= shift_in;
         hidx_ff     <= hidx_in;
         left_ff     <= left_in;
         cls_ff      <= cls_in;
         stage_ff    <= stage_in;
         tcount_ff   <= tcount_in;
         found_ff    <= found_in;
         run_open_ff <= run_open_in;
      end
   end

   always_comb begin
      logic [63:0]           shift_v;
      logic [27:0]           tag_v;
      logic [31:0]           id_v;
      logic [31:0]           size_v;
      logic [31:0]           left_v;
      logic                  final_v;
      logic [2:0]            kind_v;
      logic [7:0]            tc_v;
      logic                  lst_v;
      id3_pkg::class_type    cls_v;
      logic                  run_v;
      id3_pkg::rsp_item_type run_item;
      logic                  fin_v;
      id3_pkg::rsp_item_type fin_item;

      phase_in    = phase_ff;
      pos_in      = pos_ff;
      tag_in      = tag_ff;
      shift_in    = shift_ff;
      hidx_in     = hidx_ff;
      left_in     = left_ff;
      cls_in      = cls_ff;
      stage_in    = stage_ff;
      tcount_in   = tcount_ff;
      found_in    = found_ff;
      run_open_in = run_open_ff;

      shift_v  = shift_ff;
      tag_v    = tag_ff;
      id_v     = shift_ff[63:32];
      size_v   = shift_ff[31:0];
      left_v   = left_ff;
      final_v  = 1'b0;
      kind_v   = 3'(cls_ff) - 3'd1;
      tc_v     = tcount_ff + 8'd1;
      lst_v    = 1'b0;
      cls_v    = id3_pkg::CLS_NONE;
      run_v    = 1'b0;
      run_item = '0;
      fin_v    = 1'b0;
      fin_item = '{kind: id3_pkg::KIND_FINISH, data: id3_pkg::ST_NO_TAG,
                   data_valid: 1'b1, last: 1'b1};

      if (process && phase_ff != id3_pkg::PH_DONE) begin
         if (pos_ff != id3_pkg::POS_MAX) pos_in = pos_ff + 1'b1;

         unique case (phase_ff)
            id3_pkg::PH_TAG_HDR: begin
               // keep "ID3" and the four size bytes
               if (hidx_ff < 4'd3 || hidx_ff >= 4'd6) shift_v = {shift_ff[55:0], byte_ff};
               shift_in = shift_v;
               hidx_in  = hidx_ff + 4'd1;
               if (hidx_ff == 4'd9) begin
                  hidx_in = '0;
                  if (shift_v[55:32] != id3_pkg::TAG_MAGIC) begin
                     fin_v         = 1'b1;
                     fin_item.data = id3_pkg::ST_NO_TAG;
                     phase_in      = id3_pkg::PH_DONE;
                  end else begin
                     tag_v  = {shift_v[30:24], shift_v[22:16], shift_v[14:8], shift_v[6:0]};
                     tag_in = tag_v;
                     if (pos_in < {1'b0, tag_v}) begin
                        phase_in = id3_pkg::PH_FRAME_HDR;
                        shift_in = '0;
                     end else begin
                        fin_v         = 1'b1;
                        fin_item.data = id3_pkg::ST_TAG_END;
                        phase_in      = id3_pkg::PH_DONE;
                     end
                  end
               end
            end
            id3_pkg::PH_FRAME_HDR: begin
               // flag bytes are not kept
               if (hidx_ff < 4'd8) shift_v = {shift_ff[55:0], byte_ff};
               shift_in = shift_v;
               hidx_in  = hidx_ff + 4'd1;
               if (hidx_ff == 4'd9) begin
                  hidx_in  = '0;
                  shift_in = '0;
                  id_v     = shift_v[63:32];
                  size_v   = shift_v[31:0];
                  if (id_v[31:24] == 8'd0) begin
                     fin_v         = 1'b1;
                     fin_item.data = id3_pkg::ST_PADDING;
                     phase_in      = id3_pkg::PH_DONE;
                  end else if (size_v == 32'd0 || size_v > max_frame_size) begin
                     fin_v         = 1'b1;
                     fin_item.data = id3_pkg::ST_BAD_SIZE;
                     phase_in      = id3_pkg::PH_DONE;
                  end else begin
                     for (int i = 0; i < 4; i++) begin
                        if (id_v == id3_pkg::FRAME_IDS[i] && !found_ff[i])
                           cls_v = id3_pkg::class_type'(3'(i + 1));
                     end
                     cls_in    = cls_v;
                     left_in   = size_v;
                     stage_in  = id3_pkg::STG_ENC;
                     tcount_in = '0;
                     phase_in  = id3_pkg::PH_PAYLOAD;
                  end
               end
            end
            id3_pkg::PH_PAYLOAD: begin
               left_v  = left_ff - 32'd1;
               left_in = left_v;
               final_v = (left_v == 32'd0);
               if (cls_ff == id3_pkg::CLS_TITLE || cls_ff == id3_pkg::CLS_ARTIST ||
                   cls_ff == id3_pkg::CLS_ALBUM) begin
                  if (stage_ff == id3_pkg::STG_ENC) begin
                     stage_in = id3_pkg::STG_MIME;
                  end else if (stage_ff == id3_pkg::STG_MIME) begin
                     if (byte_ff == 8'd0 || tcount_ff >= max_text_bytes) begin
                        stage_in = id3_pkg::STG_TYPE;
                        if (byte_ff == 8'd0 && run_open_ff) begin
                           // NUL closes the run with an empty marker
                           run_v       = 1'b1;
                           run_item    = '{kind: kind_v, data: 8'd0,
                                           data_valid: 1'b0, last: 1'b1};
                           run_open_in = 1'b0;
                        end
                     end else begin
                        lst_v       = final_v || tc_v >= max_text_bytes;
                        tcount_in   = tc_v;
                        run_v       = 1'b1;
                        run_item    = '{kind: kind_v, data: byte_ff,
                                        data_valid: 1'b1, last: lst_v};
                        found_in    = found_ff | (4'b0001 << kind_v[1:0]);
                        run_open_in = !lst_v;
                        if (lst_v) stage_in = id3_pkg::STG_TYPE;
                     end
                  end
               end else if (cls_ff == id3_pkg::CLS_PICTURE) begin
                  unique case (stage_ff)
                     id3_pkg::STG_ENC:  stage_in = id3_pkg::STG_MIME;
                     id3_pkg::STG_MIME: if (byte_ff == 8'd0) stage_in = id3_pkg::STG_TYPE;
                     id3_pkg::STG_TYPE: stage_in = id3_pkg::STG_DESC;
                     id3_pkg::STG_DESC: if (byte_ff == 8'd0) stage_in = id3_pkg::STG_IMAGE;
                     default: begin
                        run_v       = 1'b1;
                        run_item    = '{kind: id3_pkg::KIND_PICTURE, data: byte_ff,
                                        data_valid: 1'b1, last: final_v};
                        found_in    = found_ff | 4'b1000;
                        run_open_in = !final_v;
                     end
                  endcase
               end
               if (final_v) begin
                  if (pos_in < {1'b0, tag_ff}) begin
                     phase_in = id3_pkg::PH_FRAME_HDR;
                     hidx_in  = '0;
                     shift_in = '0;
                  end else begin
                     fin_v         = 1'b1;
                     fin_item.data = id3_pkg::ST_TAG_END;
                     phase_in      = id3_pkg::PH_DONE;
                  end
               end
            end
            default: ;
         endcase

         if (fe_ff && phase_in != id3_pkg::PH_DONE) begin
            fin_v         = 1'b1;
            fin_item.data = (phase_in == id3_pkg::PH_TAG_HDR) ? id3_pkg::ST_NO_TAG
                                                               : id3_pkg::ST_FILE_ENDED;
            phase_in      = id3_pkg::PH_DONE;
         end
         if (fin_v) run_open_in = 1'b0;
      end

      // run result always precedes the finish result
      push.push0 = run_v || fin_v;
      push.push1 = run_v && fin_v;
      push.item0 = run_v ? run_item : fin_item;
      push.item1 = fin_item;
   end

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == id3_pkg::PH_DONE |=> phase_ff == id3_pkg::PH_DONE)
      else $error("parser left finished state without reset");

   a_push1_is_finish: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0 && push.item1.kind == id3_pkg::KIND_FINISH &&
                     push.item0.kind != id3_pkg::KIND_FINISH)
      else $error("second result of an item is not the finish");

   a_held_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_room |=> in_valid_ff && $stable(byte_ff))
      else $error("held item lost while the queue was full");

endmodule

[hdl/id3_rsp_fifo.sv]
module id3_rsp_fifo #(
   parameter int DEPTH = id3_pkg::RSP_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  id3_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_data,
   output logic              rsp_data_valid,
   output logic              rsp_last
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   id3_pkg::rsp_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   id3_pkg::rsp_item_type head;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_next   = ptr_inc(wr_ff);
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));
   assign head      = entry_ff[rd_ff];

   assign rsp_kind       = head.kind;
   assign rsp_data       = head.data;
   assign rsp_data_valid = head.data_valid;
   assign rsp_last       = head.last;

   always_comb begin
      wr_in = wr_ff;
      if (push.push1) wr_in = ptr_inc(wr_next);
      else if (push.push0) wr_in = wr_next;
      rd_in    = pop ? ptr_inc(rd_ff) : rd_ff;
      count_in = count_ff + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push0) entry_ff[wr_ff] <= push.item0;
      if (push.push1) entry_ff[wr_next] <= push.item1;
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> room)
      else $error("result pushed without two free slots");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("response queue overflow");

   a_finish_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == id3_pkg::KIND_FINISH |-> rsp_last && rsp_data_valid)
      else $error("finish result without last");

endmodule

[hdl/id3v2_tag_frame_parser.sv]
// ID3v2 tag frame parser.
// req channel: one file byte per item (req_data_byte) with req_file_end marking
// the last byte. rsp channel: field bytes of the first non-empty title, artist
// and album text frames and the image bytes of the first picture frame, each
// run closed by rsp_last, then one finish item (kind 4) whose data is the
// status. An item with rsp_data_valid low and rsp_last high closes a text run
// at its NUL. Runs left open at a file-ended finish are to be dropped.
// csr channel: index 0 writes max_frame_size, index 1 max_text_bytes; other
// indexes are ignored. csr_ready is always high; write only while idle.
// An accepted byte is registered in the input register, and its results are
// registered in the response queue that drives rsp.
// Throughput: one byte per cycle while req_stall is low. A byte produces at
// most two results; the response queue (RSP_DEPTH entries) must hold two free
// slots before the byte in the input register is processed, so req_stall rises
// once the queue backs up under rsp_stall. No result is lost while it is held.
// Reset (synchronous) restarts parsing at the tag header, empties the queue
// and restores the register defaults. After the finish item every byte is
// accepted and dropped until reset.
module id3v2_tag_frame_parser #(
   parameter int RSP_DEPTH = id3_pkg::RSP_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_file_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_kind,
   output logic [7:0]                      rsp_data,
   output logic                            rsp_data_valid,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [id3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata
);

   logic [31:0]       max_frame_size_ff;
   logic [7:0]        max_text_bytes_ff;
   logic              room;
   id3_pkg::push_type push;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_size_ff <= id3_pkg::MAX_FRAME_SIZE_RST;
         max_text_bytes_ff <= id3_pkg::MAX_TEXT_BYTES_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == id3_pkg::CSR_MAX_FRAME_SIZE) max_frame_size_ff <= csr_wdata;
         if (csr_index == id3_pkg::CSR_MAX_TEXT_BYTES) max_text_bytes_ff <= csr_wdata[7:0];
      end
   end

   id3_parse_core u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_file_end   (req_file_end),
      .max_frame_size (max_frame_size_ff),
      .max_text_bytes (max_text_bytes_ff),
      .rsp_room       (room),
      .push           (push)
   );

   id3_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .room           (room),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data       (rsp_data),
      .rsp_data_valid (rsp_data_valid),
      .rsp_last       (rsp_last)
   );

endmodule
